// File: sv/apsp_pkg.sv
// Shared types, constants and helpers for the all-pairs shortest path engine.
package apsp_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int KIND_W        = 2;
  localparam int NODE_W        = 6;
  localparam int WEIGHT_W      = 16;
  localparam int DIST_W        = 22;
  localparam int CNT_W         = 7;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(64);

  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_RUN   = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_COPY,
    ST_COPY_END,
    ST_LOAD,
    ST_ROW_IK,
    ST_ROW_GO,
    ST_RELAX,
    ST_ROUND_END,
    ST_RESP
  } state_t;

  // {unreachable, value}
  typedef logic [DIST_W:0]   dent_t;
  typedef logic [WEIGHT_W:0] eent_t;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
    if (s[DIST_W] != s[DIST_W-1]) begin
      return s[DIST_W] ? DIST_MIN : DIST_MAX;
    end
    return s[DIST_W-1:0];
  endfunction

endpackage

// File: sv/apsp_if.sv
// Request and response channel interfaces.
interface apsp_req_if import apsp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [NODE_W-1:0]          src_node;
  logic [NODE_W-1:0]          dst_node;
  logic signed [WEIGHT_W-1:0] weight;

  modport source(output valid, kind, src_node, dst_node, weight, input ready);
  modport sink(input valid, kind, src_node, dst_node, weight, output ready);
endinterface

interface apsp_rsp_if import apsp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        reply_kind;
  logic signed [DIST_W-1:0] distance;
  logic                     unreachable;

  modport source(output valid, reply_kind, distance, unreachable, input ready);
  modport sink(input valid, reply_kind, distance, unreachable, output ready);
endinterface

// File: sv/apsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module apsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/apsp_cell.sv
// One cell of the pivot-row chain: holds one distance entry, takes its neighbor's on shift.
module apsp_cell import apsp_pkg::*; (
  input  logic  clk,
  input  logic  shift,
  input  dent_t d_in,
  output dent_t q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d_in;
    end
  end

endmodule

// File: sv/all_pairs_shortest_paths.sv
// All-pairs shortest path engine: top level with sequencer, matrices and pivot-row chain.
//
// Channels: req (sink) carries kind, src_node, dst_node, weight; rsp (source)
// returns reply_kind, distance, unreachable, exactly one transfer per request.
// cfg_we/cfg_wdata write node_count; write only while the engine is idle.
// A run streams the distance matrix one entry per cycle within a row through a
// single relax unit; the pivot row sits in a chain of MAX_NODES cells that
// rotates one step per entry. Two distance banks alternate as source and target per pivot.
// One request is in work at a time; req.ready is high only when idle.
// Reset: node_count returns to 64 and a clearing pass sweeps the
// matrices, with req.ready low; no response is produced for it.
// When rsp stalls, a finished response waits in the output register; the
// next request is taken meanwhile, and its response waits until the register frees.
module all_pairs_shortest_paths import apsp_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  apsp_req_if.sink         req,
  apsp_rsp_if.source       rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 2 ** AW;
  localparam logic [NW-1:0] J_LAST = NW'(MAX_NODES - 1);

  state_t state, state_next;

  logic [CNT_W-1:0] node_count;
  logic [NW:0]      n_eff, n_eff_next;
  logic             boot, cur;
  logic [AW-1:0]    a_cnt, cp_a, rx_a;
  logic [NW-1:0]    k_cnt, i_cnt, j_cnt, rx_j;
  logic             ld_v, rx_v, cp_v;
  dent_t            dik;
  kind_t            r_kind;
  logic [NW-1:0]    r_u, r_v;
  logic             r_ok;
  logic [DIST_W-1:0] rs_dist;
  logic             rs_unr;
  logic             o_valid, o_unr;
  kind_t            o_kind;
  logic [DIST_W-1:0] o_dist;

  logic          accept, req_ok, rsp_load;
  logic          e_we, d_we0, d_we1;
  logic [AW-1:0] e_waddr, d_waddr, d_raddr;
  eent_t         e_wdata, e_rdata;
  dent_t         d_wdata, rd0, rd1, rd_sel, relax_d, clr_d;
  logic [DIST_W-1:0] s_sum;
  logic          take, a_last, j_last, i_last, k_last;

  dent_t cq [MAX_NODES];
  dent_t chain_in;
  logic  shift;

  assign accept   = req.valid && req.ready;
  assign req_ok   = (int'(req.src_node) < MAX_NODES) && (int'(req.dst_node) < MAX_NODES);
  assign a_last   = (a_cnt == '1);
  assign j_last   = (j_cnt == J_LAST);
  assign i_last   = ({1'b0, i_cnt} == n_eff - 1'b1);
  assign k_last   = ({1'b0, k_cnt} == n_eff - 1'b1);
  assign rsp_load = (state == ST_RESP) && (!o_valid || rsp.ready);

  always_comb begin
    if (int'(node_count) > MAX_NODES) begin
      n_eff_next = (NW+1)'(MAX_NODES);
    end else if (node_count == '0) begin
      n_eff_next = (NW+1)'(1);
    end else begin
      n_eff_next = (NW+1)'(node_count);
    end
  end

  // pivot-row chain
  assign shift    = ld_v || rx_v;
  assign chain_in = ld_v ? rd_sel : cq[0];

  for (genvar c = 0; c < MAX_NODES; c++) begin : g_cell
    if (c == MAX_NODES - 1) begin : g_tail
      apsp_cell u_cell (.clk(clk), .shift(shift), .d_in(chain_in), .q(cq[c]));
    end else begin : g_body
      apsp_cell u_cell (.clk(clk), .shift(shift), .d_in(cq[c+1]), .q(cq[c]));
    end
  end

  // relax unit
  assign rd_sel = cur ? rd1 : rd0;
  assign s_sum  = sat_add(dik[DIST_W-1:0], cq[0][DIST_W-1:0]);
  assign take   = !dik[DIST_W] && !cq[0][DIST_W] && ({1'b0, rx_j} < n_eff) &&
                  (rd_sel[DIST_W] || !($signed(rd_sel[DIST_W-1:0]) < $signed(s_sum)));
  assign relax_d = take ? {1'b0, s_sum} : rd_sel;
  assign clr_d   = {(a_cnt[AW-1:NW] != a_cnt[NW-1:0]), {DIST_W{1'b0}}};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (a_last) state_next = boot ? ST_IDLE : ST_RESP;
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(req.kind))
            KIND_CLEAR: state_next = ST_CLEAR;
            KIND_ADD:   state_next = ST_RESP;
            KIND_RUN:   state_next = ST_COPY;
            KIND_READ:  state_next = ST_RD_ISSUE;
            default:    state_next = ST_RESP;
          endcase
        end
      end
      ST_RD_ISSUE:  state_next = ST_RD_WAIT;
      ST_RD_WAIT:   state_next = ST_RESP;
      ST_COPY:      if (a_last) state_next = ST_COPY_END;
      ST_COPY_END:  state_next = ST_LOAD;
      ST_LOAD:      if (j_last) state_next = ST_ROW_IK;
      ST_ROW_IK:    state_next = ST_ROW_GO;
      ST_ROW_GO:    state_next = ST_RELAX;
      ST_RELAX:     if (j_last) state_next = i_last ? ST_ROUND_END : ST_ROW_IK;
      ST_ROUND_END: state_next = k_last ? ST_RESP : ST_LOAD;
      ST_RESP:      if (rsp_load) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    req.ready = (state == ST_IDLE);
    e_we      = 1'b0;
    e_waddr   = a_cnt;
    e_wdata   = {1'b1, {WEIGHT_W{1'b0}}};
    d_we0     = 1'b0;
    d_we1     = 1'b0;
    d_waddr   = a_cnt;
    d_wdata   = clr_d;
    d_raddr   = {i_cnt, j_cnt};
    case (state)
      ST_CLEAR: begin
        e_we    = 1'b1;
        e_wdata = {clr_d[DIST_W], {WEIGHT_W{1'b0}}};
        d_we0   = 1'b1;
        d_we1   = 1'b1;
      end
      ST_IDLE: begin
        e_we    = accept && (kind_t'(req.kind) == KIND_ADD) && req_ok;
        e_waddr = {NW'(req.src_node), NW'(req.dst_node)};
        e_wdata = {1'b0, req.weight};
      end
      ST_RD_ISSUE: d_raddr = {r_u, r_v};
      ST_LOAD:     d_raddr = {k_cnt, j_cnt};
      ST_ROW_IK:   d_raddr = {i_cnt, k_cnt};
      default: ;
    endcase
    if (cp_v) begin
      d_we0   = 1'b1;
      d_we1   = 1'b1;
      d_waddr = cp_a;
      d_wdata = {e_rdata[WEIGHT_W], {(DIST_W-WEIGHT_W){e_rdata[WEIGHT_W-1]}},
                 e_rdata[WEIGHT_W-1:0]};
    end else if (rx_v) begin
      d_we0   = cur;
      d_we1   = !cur;
      d_waddr = rx_a;
      d_wdata = relax_d;
    end
  end

  apsp_ram #(.WIDTH(WEIGHT_W+1), .DEPTH(DEPTH)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(a_cnt), .rdata(e_rdata)
  );

  apsp_ram #(.WIDTH(DIST_W+1), .DEPTH(DEPTH)) u_dist0 (
    .clk(clk), .we(d_we0), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(rd0)
  );

  apsp_ram #(.WIDTH(DIST_W+1), .DEPTH(DEPTH)) u_dist1 (
    .clk(clk), .we(d_we1), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(rd1)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      boot       <= 1'b1;
      cur        <= 1'b0;
      node_count <= NODE_COUNT_RST;
      a_cnt      <= '0;
      ld_v       <= 1'b0;
      rx_v       <= 1'b0;
      cp_v       <= 1'b0;
      o_valid    <= 1'b0;
    end else begin
      state <= state_next;
      ld_v  <= (state == ST_LOAD);
      rx_v  <= (state == ST_RELAX);
      cp_v  <= (state == ST_COPY);
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (state == ST_CLEAR || state == ST_COPY) begin
        a_cnt <= a_cnt + 1'b1;
      end
      if (state == ST_CLEAR && a_last) begin
        boot <= 1'b0;
      end
      if (accept) begin
        a_cnt <= '0;
      end
      if (state == ST_ROUND_END) begin
        cur <= !cur;
      end
      if (rsp_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cp_a <= a_cnt;
    rx_a <= {i_cnt, j_cnt};
    rx_j <= j_cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          r_kind  <= kind_t'(req.kind);
          r_u     <= NW'(req.src_node);
          r_v     <= NW'(req.dst_node);
          r_ok    <= req_ok;
          rs_dist <= '0;
          rs_unr  <= 1'b0;
          n_eff   <= n_eff_next;
          k_cnt   <= '0;
        end
      end
      ST_RD_WAIT: begin
        rs_unr  <= !r_ok || rd_sel[DIST_W];
        rs_dist <= (!r_ok || rd_sel[DIST_W]) ? '0 : rd_sel[DIST_W-1:0];
      end
      ST_COPY_END: begin
        i_cnt <= '0;
        j_cnt <= '0;
      end
      ST_LOAD:  j_cnt <= j_last ? '0 : j_cnt + 1'b1;
      ST_ROW_GO: dik <= rd_sel;
      ST_RELAX: begin
        j_cnt <= j_last ? '0 : j_cnt + 1'b1;
        if (j_last && !i_last) begin
          i_cnt <= i_cnt + 1'b1;
        end
      end
      ST_ROUND_END: begin
        k_cnt <= k_cnt + 1'b1;
        i_cnt <= '0;
        j_cnt <= '0;
      end
      default: ;
    endcase
    if (rsp_load) begin
      o_kind <= r_kind;
      o_dist <= rs_dist;
      o_unr  <= rs_unr;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.reply_kind  = o_kind;
  assign rsp.distance    = o_dist;
  assign rsp.unreachable = o_unr;

`ifndef SYNTHESIS
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RELAX) |-> ({1'b0, i_cnt} < n_eff))
    else $error("relax row outside node count");

  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND_END) |=> (cur != $past(cur)))
    else $error("distance bank did not flip at end of round");

  a_no_write_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (!rx_v && !cp_v))
    else $error("matrix write while loading pivot row");

  a_quiet_reply: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.reply_kind != KIND_READ) |-> (rsp.distance == '0 && !rsp.unreachable))
    else $error("non-read reply carries a distance");
`endif

endmodule

// File: test/all_pairs_shortest_paths_tb.sv
// Testbench for the all-pairs shortest path engine: shadow distance model with randomized traffic.
`timescale 1ns / 100ps

module all_pairs_shortest_paths_tb;
  import apsp_pkg::*;

  localparam int NN   = 64;
  localparam int DHI  = (1 << (DIST_W - 1)) - 1;
  localparam int DLO  = -(1 << (DIST_W - 1));

  typedef struct {
    kind_t              reply_kind;
    logic signed [21:0] distance;
    logic               unreachable;
  } reply_t;

  class path_scoreboard;
    int     edge_w[NN][NN];
    bit     edge_inf[NN][NN];
    int     dist_v[NN][NN];
    bit     dist_inf[NN][NN];
    int     node_count;
    int     errors;
    reply_t replies[$];

    function new();
      node_count = 64;
      errors = 0;
      clear_graph();
    endfunction

    function void clear_graph();
      for (int i = 0; i < NN; i++) begin
        for (int j = 0; j < NN; j++) begin
          edge_w[i][j] = 0;
          dist_v[i][j] = 0;
          edge_inf[i][j] = (i != j);
          dist_inf[i][j] = (i != j);
        end
      end
    endfunction

    function void relax_all();
      int n;
      int s;
      int pv[NN][NN];
      bit pi[NN][NN];
      n = node_count;
      if (n < 1) n = 1;
      if (n > NN) n = NN;
      dist_v = edge_w;
      dist_inf = edge_inf;
      for (int k = 0; k < n; k++) begin
        pv = dist_v;
        pi = dist_inf;
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            if (!pi[i][k] && !pi[k][j]) begin
              s = pv[i][k] + pv[k][j];
              if (s > DHI) s = DHI;
              if (s < DLO) s = DLO;
              if (pi[i][j] || pv[i][j] >= s) begin
                dist_v[i][j] = s;
                dist_inf[i][j] = 1'b0;
              end
            end
          end
        end
      end
    endfunction

    function void note_request(kind_t kind, int src, int dst, logic signed [15:0] w);
      reply_t r;
      r.reply_kind = kind;
      r.distance = '0;
      r.unreachable = 1'b0;
      case (kind)
        KIND_CLEAR: clear_graph();
        KIND_ADD: begin
          edge_w[src][dst] = int'(w);
          edge_inf[src][dst] = 1'b0;
        end
        KIND_RUN: relax_all();
        default: begin
          if (dist_inf[src][dst]) r.unreachable = 1'b1;
          else r.distance = dist_v[src][dst][21:0];
        end
      endcase
      replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] kind, logic signed [21:0] d, logic unr);
      reply_t e;
      if (replies.size() == 0) begin
        $error("unexpected reply: reply_kind %0d distance %0d", kind, d);
        errors++;
        return;
      end
      e = replies.pop_front();
      if (kind !== e.reply_kind) begin
        $error("reply_kind: expected %0d, actual %0d", e.reply_kind, kind);
        errors++;
      end
      if (d !== e.distance) begin
        $error("distance: expected %0d, actual %0d", e.distance, d);
        errors++;
      end
      if (unr !== e.unreachable) begin
        $error("unreachable: expected %0d, actual %0d", e.unreachable, unr);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  apsp_req_if req ();
  apsp_rsp_if rsp ();

  all_pairs_shortest_paths u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req.sink),
    .rsp       (rsp.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  path_scoreboard sb;
  int burst_left;
  int hold_cycles;
  bit hold_request;
  int stall_mode;
  int items_sent;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #40_000_000;
    $display("all_pairs_shortest_paths regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      sb.note_request(kind_t'(req.kind), req.src_node, req.dst_node, req.weight);
    if (!rst && rsp.valid && rsp.ready)
      sb.check_reply(rsp.reply_kind, rsp.distance, rsp.unreachable);
  end

  // receiver: long hold on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_cycles = 0;
      stall_mode = 0;
    end else begin
      if (hold_request && hold_cycles == 0) begin
        hold_request = 1'b0;
        hold_cycles = 300;
      end
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rsp.ready <= 1'b1;
          1: rsp.ready <= ($urandom_range(0, 9) < 7);
          default: rsp.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send(kind_t kind, int src, int dst, int w);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    req.valid    <= 1'b1;
    req.kind     <= kind;
    req.src_node <= src[5:0];
    req.dst_node <= dst[5:0];
    req.weight   <= w[15:0];
    do @(posedge clk); while (!req.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic set_node_count(int n);
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= n[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.node_count = n;
  endtask

  function automatic int pick_node(int n);
    if (n > NN) n = NN;
    if (n < 1) n = 1;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, n - 1);
    return $urandom_range(0, NN - 1);
  endfunction

  function automatic int pick_weight();
    if ($urandom_range(0, 3) == 0) return $signed(16'($urandom()));
    return $urandom_range(0, 300) - 60;
  endfunction

  task automatic graph_phase(int n, int adds, int reads, bit wipe);
    set_node_count(n);
    if (wipe) send(KIND_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), 0);
    repeat (adds) send(KIND_ADD, pick_node(n), pick_node(n), pick_weight());
    send(KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
    repeat (reads) send(KIND_READ, pick_node(n), pick_node(n), $urandom());
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.kind = '0;
    req.src_node = '0;
    req.dst_node = '0;
    req.weight = '0;
    burst_left = 0;
    hold_request = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!req.ready) @(posedge clk);

    // directed
    send(KIND_READ, 0, 0, 0);
    send(KIND_READ, 0, 1, 0);
    set_node_count(4);
    send(KIND_ADD, 0, 1, 32767);
    send(KIND_ADD, 1, 2, -32768);
    send(KIND_ADD, 2, 2, -1);
    send(KIND_ADD, 63, 63, 5);
    send(KIND_ADD, 63, 0, 0);
    send(KIND_ADD, 3, 63, 7);
    send(KIND_ADD, 2, 3, 10);
    send(KIND_ADD, 3, 0, 10);
    send(KIND_RUN, 0, 0, 0);
    send(KIND_READ, 0, 2, 0);
    send(KIND_READ, 2, 2, 0);
    send(KIND_READ, 3, 63, 0);
    send(KIND_READ, 63, 63, 0);
    send(KIND_READ, 3, 1, 0);
    set_node_count(0);
    send(KIND_RUN, 0, 0, 0);
    send(KIND_READ, 1, 2, 0);
    send(KIND_READ, 0, 2, 0);
    send(KIND_CLEAR, 63, 63, -1);
    send(KIND_READ, 2, 2, 0);
    send(KIND_READ, 63, 0, 0);

    // random graphs on small node counts
    hold_request = 1'b1;
    while (items_sent < 70)
      graph_phase($urandom_range(1, 8), $urandom_range(4, 12), $urandom_range(3, 8),
                  $urandom_range(0, 3) == 0);

    // full-size runs, with a negative cycle that saturates
    set_node_count(127);
    send(KIND_CLEAR, 0, 0, 0);
    send(KIND_ADD, 40, 41, -32768);
    send(KIND_ADD, 41, 40, -32768);
    send(KIND_ADD, 62, 63, 32767);
    repeat (6) send(KIND_ADD, $urandom_range(0, 63), $urandom_range(0, 63), pick_weight());
    send(KIND_RUN, 0, 0, 0);
    send(KIND_READ, 40, 40, 0);
    send(KIND_READ, 62, 63, 0);
    repeat (3) send(KIND_READ, $urandom_range(0, 63), $urandom_range(0, 63), 0);
    graph_phase(64, 4, 5, 1'b1);

    req.valid <= 1'b0;
    while (sb.replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("all_pairs_shortest_paths regression: pass");
    else
      $display("all_pairs_shortest_paths regression: fail");
    $finish;
  end

endmodule
